>>> rtl/rpn_stack_alu_core_defines.svh
// Assertion helpers for the RPN stack ALU
`ifndef RPN_STACK_ALU_CORE_DEFINES_SVH
`define RPN_STACK_ALU_CORE_DEFINES_SVH

// same-cycle implication
`define RSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rsa_pkg.sv
package rsa_pkg;

  localparam int DATA_W          = 32;
  localparam int OPC_W           = 3;
  localparam int IDX_W           = 10;
  localparam int ST_W            = 3;
  localparam int DEPTH_W         = 11;
  localparam int STACK_DEPTH_DEF = 1024;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_ADD      = 3'd2,
    OP_SUB      = 3'd3,
    OP_MUL      = 3'd4,
    OP_DIV      = 3'd5,
    OP_PEEK_TOP = 3'd6,
    OP_PEEK_BOT = 3'd7
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FEW   = 3'd2,
    ST_DIV0  = 3'd3,
    ST_RANGE = 3'd4,
    ST_FULL  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ADD,
    A_MUL,
    A_NEGA,
    A_NEGB,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_RD_B,
    S_RD_A,
    S_ALU,
    S_DONE
  } ctl_state_t;

endpackage

>>> rtl/rpn_stack_alu_core.sv
// Channel | Signals                                         | Dir
// input   | in_valid, in_ready, opcode, operand, peek_index | in
// output  | out_valid, out_ready, result_value, status,     | out
//         | depth_now                                       |
//
// One item at a time; in_ready is high only while idle.
// Accept to result register: push ends at decode; pop and peek add a read wait;
// arithmetic reads b then a and runs the ALU; errors and divide by zero end early.
// Mul and div run 32 steps of the shared adder; the next item waits until idle again.
// A finished result waits in the output register while out_ready is low.
// rst is synchronous: empty stack, no result pending. Memory is not cleared.
`include "rpn_stack_alu_core_defines.svh"

module rpn_stack_alu_core #(
  parameter int STACK_DEPTH = rsa_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rsa_pkg::OPC_W-1:0]          opcode,
  input  logic signed [rsa_pkg::DATA_W-1:0]  operand,
  input  logic [rsa_pkg::IDX_W-1:0]          peek_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rsa_pkg::DATA_W-1:0]  result_value,
  output logic [rsa_pkg::ST_W-1:0]           status,
  output logic [rsa_pkg::DEPTH_W-1:0]        depth_now
);
  import rsa_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  ctl_state_t        state, state_next;
  opcode_t           opc_r;
  logic [DATA_W-1:0] operand_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CW-1:0]     cnt, cnt_m1, cnt_m2;
  logic [DATA_W-1:0] b_r, val_r;
  status_t           st_r;
  logic [XW-1:0]     idx_x, cnt_x, top_x;
  logic              is_arith, idx_bad, full, div0;
  logic              push_go;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  alu_req_t          alu_req;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  assign cnt_m1   = cnt - CW'(1);
  assign cnt_m2   = cnt - CW'(2);
  assign idx_x    = XW'(idx_r);
  assign cnt_x    = XW'(cnt);
  assign top_x    = cnt_x - idx_x - XW'(1);
  assign idx_bad  = (idx_x >= cnt_x);
  assign full     = (cnt == CW'(STACK_DEPTH));
  assign is_arith = (opc_r == OP_ADD) || (opc_r == OP_SUB) ||
                    (opc_r == OP_MUL) || (opc_r == OP_DIV);
  assign div0     = (opc_r == OP_DIV) && (b_r == '0);
  assign push_go  = (state == S_DECODE) && (opc_r == OP_PUSH) && !full;

  rsa_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rsa_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (mem_rdata),
    .b      (b_r),
    .done   (alu_done),
    .result (alu_result)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (opc_r)
          OP_PUSH:     state_next = S_DONE;
          OP_POP:      state_next = (cnt == '0) ? S_DONE : S_RD_WAIT;
          OP_PEEK_TOP,
          OP_PEEK_BOT: state_next = idx_bad ? S_DONE : S_RD_WAIT;
          default:     state_next = (cnt < CW'(2)) ? S_DONE : S_RD_B;
        endcase
      end
      S_RD_WAIT: state_next = S_DONE;
      S_RD_B:    state_next = S_RD_A;
      S_RD_A:    state_next = div0 ? S_DONE : S_ALU;
      S_ALU:     state_next = alu_done ? S_DONE : S_ALU;
      S_DONE:    state_next = (!out_valid || out_ready) ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    mem_we        = 1'b0;
    mem_waddr     = cnt_m2[AW-1:0];
    mem_wdata     = alu_result;
    mem_raddr     = cnt_m1[AW-1:0];
    alu_req.start = 1'b0;
    case (opc_r)
      OP_SUB:  alu_req.op = ALU_SUB;
      OP_MUL:  alu_req.op = ALU_MUL;
      OP_DIV:  alu_req.op = ALU_DIV;
      default: alu_req.op = ALU_ADD;
    endcase
    case (state)
      S_DECODE: begin
        if (opc_r == OP_PUSH && !full) begin
          mem_we    = 1'b1;
          mem_waddr = cnt[AW-1:0];
          mem_wdata = operand_r;
        end
        if (opc_r == OP_PEEK_TOP) begin
          mem_raddr = top_x[AW-1:0];
        end else if (opc_r == OP_PEEK_BOT) begin
          mem_raddr = idx_x[AW-1:0];
        end
      end
      S_RD_B: begin
        mem_raddr = cnt_m2[AW-1:0];
      end
      S_RD_A: begin
        alu_req.start = !div0;
      end
      S_ALU: begin
        mem_we = alu_done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            opc_r     <= opcode_t'(opcode);
            operand_r <= operand;
            idx_r     <= peek_index;
          end
        end
        S_DECODE: begin
          st_r  <= ST_OK;
          val_r <= '0;
          case (opc_r)
            OP_PUSH: begin
              if (full) begin
                st_r <= ST_FULL;
              end else begin
                cnt <= cnt + CW'(1);
              end
            end
            OP_POP: begin
              if (cnt == '0) begin
                st_r <= ST_EMPTY;
              end else begin
                cnt <= cnt_m1;
              end
            end
            OP_PEEK_TOP,
            OP_PEEK_BOT: begin
              if (idx_bad) begin
                st_r <= ST_RANGE;
              end
            end
            default: begin
              if (cnt < CW'(2)) begin
                st_r <= ST_FEW;
              end
            end
          endcase
        end
        S_RD_WAIT: begin
          val_r <= mem_rdata;
        end
        S_RD_B: begin
          b_r <= mem_rdata;
        end
        S_RD_A: begin
          if (div0) begin
            st_r <= ST_DIV0;
            cnt  <= cnt_m2;
          end
        end
        S_ALU: begin
          if (alu_done) begin
            val_r <= alu_result;
            cnt   <= cnt_m1;
          end
        end
        default: begin
        end
      endcase

      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid    <= 1'b1;
        result_value <= val_r;
        status       <= st_r;
        depth_now    <= DEPTH_W'(cnt);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RSA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CW'(STACK_DEPTH), "stack count beyond depth")
  `RSA_ASSERT_NOW(a_err_zero, out_valid && status != ST_OK, result_value == '0, "error value set")
  `RSA_ASSERT_NOW(a_alu_owner, alu_done, state == S_ALU && is_arith, "stray ALU done")
  `RSA_ASSERT_NEXT(a_push_grow, push_go, cnt == $past(cnt) + CW'(1), "push lost")

endmodule

>>> rtl/rsa_stack.sv
module rsa_stack #(
  parameter int DEPTH = rsa_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(rsa_pkg::STACK_DEPTH_DEF)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [rsa_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [rsa_pkg::DATA_W-1:0] rdata
);
  import rsa_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rsa_alu.sv
module rsa_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  rsa_pkg::alu_req_t          req,
  input  logic [rsa_pkg::DATA_W-1:0] a,
  input  logic [rsa_pkg::DATA_W-1:0] b,
  output logic                       done,
  output logic [rsa_pkg::DATA_W-1:0] result
);
  import rsa_pkg::*;

  localparam int SW  = DATA_W + 2;
  localparam int CNW = $clog2(DATA_W);

  alu_state_t        phase, phase_next;
  alu_op_t           op_r;
  logic [DATA_W-1:0] xr, yr, acc;
  logic [CNW-1:0]    cnt;
  logic              negq;
  logic [SW-1:0]     add_x, add_y, add_s;
  logic              add_sub;
  logic              last;

  assign last = (cnt == CNW'(DATA_W - 1));

  // one shared adder / subtractor
  always_comb begin
    add_x   = '0;
    add_y   = {2'b00, xr};
    add_sub = 1'b1;
    case (phase)
      A_ADD: begin
        add_x   = {2'b00, xr};
        add_y   = {2'b00, yr};
        add_sub = (op_r == ALU_SUB);
      end
      A_MUL: begin
        add_x   = {2'b00, acc};
        add_y   = {2'b00, xr};
        add_sub = 1'b0;
      end
      A_NEGB: begin
        add_y = {2'b00, yr};
      end
      A_DIV: begin
        add_x = {1'b0, acc, xr[DATA_W-1]};
        add_y = {2'b00, yr};
      end
      default: begin
        add_x = '0;
      end
    endcase
    add_s = add_sub ? (add_x - add_y) : (add_x + add_y);
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            ALU_MUL: phase_next = A_MUL;
            ALU_DIV: phase_next = A_NEGA;
            default: phase_next = A_ADD;
          endcase
        end
      end
      A_ADD:   phase_next = A_DONE;
      A_MUL:   phase_next = last ? A_DONE : A_MUL;
      A_NEGA:  phase_next = A_NEGB;
      A_NEGB:  phase_next = A_DIV;
      A_DIV:   phase_next = last ? A_FIX : A_DIV;
      A_FIX:   phase_next = A_DONE;
      A_DONE:  phase_next = A_IDLE;
      default: phase_next = A_IDLE;
    endcase
  end

  always_comb begin
    done   = (phase == A_DONE);
    result = (op_r == ALU_DIV) ? xr : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= A_IDLE;
    end else begin
      phase <= phase_next;
      case (phase)
        A_IDLE: begin
          if (req.start) begin
            xr   <= a;
            yr   <= b;
            op_r <= req.op;
            acc  <= '0;
            cnt  <= '0;
          end
        end
        A_ADD: begin
          acc <= add_s[DATA_W-1:0];
        end
        A_MUL: begin
          if (yr[0]) begin
            acc <= add_s[DATA_W-1:0];
          end
          xr  <= {xr[DATA_W-2:0], 1'b0};
          yr  <= {1'b0, yr[DATA_W-1:1]};
          cnt <= cnt + CNW'(1);
        end
        A_NEGA: begin
          negq <= xr[DATA_W-1] ^ yr[DATA_W-1];
          if (xr[DATA_W-1]) begin
            xr <= add_s[DATA_W-1:0];
          end
        end
        A_NEGB: begin
          if (yr[DATA_W-1]) begin
            yr <= add_s[DATA_W-1:0];
          end
          acc <= '0;
          cnt <= '0;
        end
        A_DIV: begin
          if (!add_s[SW-1]) begin
            acc <= add_s[DATA_W-1:0];
            xr  <= {xr[DATA_W-2:0], 1'b1};
          end else begin
            acc <= {acc[DATA_W-2:0], xr[DATA_W-1]};
            xr  <= {xr[DATA_W-2:0], 1'b0};
          end
          cnt <= cnt + CNW'(1);
        end
        A_FIX: begin
          // floor: inexact negative quotient is -(q+1) = ~q
          if (negq) begin
            xr <= (acc != '0) ? ~xr : add_s[DATA_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
